### design/packet_deframer_checksum_defines.svh
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Shared property forms for the checker of the packet deframer.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CHECKSUM_DEFINES_SVH
`define PACKET_DEFRAMER_CHECKSUM_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define PDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packet deframer check failed");

// Next-cycle implication, checked outside of reset.
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packet deframer check failed");

`endif

### design/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Packet deframer package
// Framing codes, event codes, result type and hex digit decoding.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CK_HIGH = 2'd2;
  localparam logic [1:0] PH_CK_LOW  = 2'd3;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_INTR  = 8'h03;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_DATA = 3'd1;
  localparam logic [2:0] EV_INTR = 3'd2;
  localparam logic [2:0] EV_GOOD = 3'd3;
  localparam logic [2:0] EV_BAD  = 3'd4;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] payload_byte;
    logic [7:0] packet_length;
  } pdc_result_t;

  // Hex digit value; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] up;
    up = c & ~CASE_BIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_value = c[3:0];
    end else if (up >= 8'h41 && up <= 8'h46) begin
      hex_value = up[3:0] + 4'd9;
    end else begin
      hex_value = 4'd0;
    end
  endfunction

endpackage

### design/pdc_fsm.sv
// ----------------------------------------------------------------------------
// Packet deframer framing logic
// Framing state, running sum and length, and the result of one byte.
// ----------------------------------------------------------------------------
module pdc_fsm
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output pdc_result_t result
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] byte_count;
  logic [7:0] byte_count_next;
  logic [3:0] expected_high_nibble;
  logic [3:0] expected_high_nibble_next;
  logic [7:0] expected_sum;

  assign expected_sum = {expected_high_nibble, hex_value(rx_byte)};

  always_comb begin
    phase_next                = phase;
    running_sum_next          = running_sum;
    byte_count_next           = byte_count;
    expected_high_nibble_next = expected_high_nibble;
    result.event_kind         = EV_NONE;
    result.payload_byte       = 8'd0;
    result.packet_length      = 8'd0;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == CH_INTR) begin
          result.event_kind = EV_INTR;
        end else if (rx_byte == CH_START) begin
          running_sum_next = 8'd0;
          byte_count_next  = 8'd0;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_HASH) begin
          phase_next = PH_CK_HIGH;
        end else begin
          running_sum_next    = running_sum + rx_byte;
          byte_count_next     = byte_count + 8'd1;
          result.event_kind   = EV_DATA;
          result.payload_byte = rx_byte;
        end
      end
      PH_CK_HIGH: begin
        expected_high_nibble_next = hex_value(rx_byte);
        phase_next                = PH_CK_LOW;
      end
      PH_CK_LOW: begin
        result.event_kind    = (expected_sum == running_sum) ? EV_GOOD : EV_BAD;
        result.packet_length = byte_count;
        phase_next           = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      running_sum          <= 8'd0;
      byte_count           <= 8'd0;
      expected_high_nibble <= 4'd0;
    end else if (step) begin
      phase                <= phase_next;
      running_sum          <= running_sum_next;
      byte_count           <= byte_count_next;
      expected_high_nibble <= expected_high_nibble_next;
    end
  end

endmodule

### design/packet_deframer_checksum.sv
// ----------------------------------------------------------------------------
// Packet deframer with modulo-256 checksum check
//
//   channel   dir  tdata (low bit up)                      tuser
//   s_axis    in   rx_byte[7:0]                            -
//   m_axis    out  payload_byte[7:0], packet_length[15:8]  event_kind[2:0]
//
// One item per cycle sustained unless the output stalls; each input byte gives
// exactly one result item via an input register, then framing logic into the
// result register. Reset returns the framer to waiting for a packet start and
// empties both registers. A stalled output holds its item; the input register
// still moves into the result register in the same cycle that one is taken.
// ----------------------------------------------------------------------------
module packet_deframer_checksum
  import pdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // payload_byte[7:0], packet_length[15:8]
  output logic [2:0]  m_axis_tuser    // event_kind[2:0]
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  pdc_result_t out_item;
  pdc_result_t result;
  logic        out_free;
  logic        step;

  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  pdc_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_item.packet_length, out_item.payload_byte};
  assign m_axis_tuser  = out_item.event_kind;

endmodule

### design/pdc_checker.sv
// ----------------------------------------------------------------------------
// Packet deframer port checker
// Checks the output items of the deframer as seen on its ports.
// ----------------------------------------------------------------------------
`include "packet_deframer_checksum_defines.svh"

module pdc_checker
  import pdc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A result item that is not taken stays on the port unchanged.
  `PDC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only payload items carry a payload byte.
  `PDC_ASSERT_NOW(a_payload_zero, clk, rst, m_axis_tvalid && m_axis_tuser != EV_DATA, m_axis_tdata[7:0] == 8'd0)

  // Only packet verdicts carry a length.
  `PDC_ASSERT_NOW(a_length_zero, clk, rst, m_axis_tvalid && m_axis_tuser != EV_GOOD && m_axis_tuser != EV_BAD, m_axis_tdata[15:8] == 8'd0)

endmodule

bind packet_deframer_checksum pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
